[rtl/core/lps_pkg.sv]
// Shared types, constants and arithmetic helpers of the Legendre run generator.
`default_nettype none
package lps_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] position;
  } in_t;

  typedef struct packed {
    logic [4:0]         degree;
    logic signed [47:0] result_value;
    logic               saturated;
    logic               last;
  } out_t;

  typedef struct packed {
    logic init;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GSQ, ST_PICK, ST_EMIT, ST_TMUL, ST_DNUM, ST_DIV, ST_S1, ST_S2, ST_RMUL
  } st_t;

  localparam logic [1:0] KIND_VAL = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_DER = 2'd2;

  localparam int NCELL = 2;
  localparam logic signed [63:0] VMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN = -64'sh0000_8000_0000_0000;
  localparam logic [63:0] R_NUM = 64'h1_0000_0000;

  // Entry i holds round(2^32 / (i+1)).
  localparam logic [32:0] RECIP [0:31] = '{
    33'((R_NUM + 64'd0) / 64'd1),   33'((R_NUM + 64'd1) / 64'd2),
    33'((R_NUM + 64'd1) / 64'd3),   33'((R_NUM + 64'd2) / 64'd4),
    33'((R_NUM + 64'd2) / 64'd5),   33'((R_NUM + 64'd3) / 64'd6),
    33'((R_NUM + 64'd3) / 64'd7),   33'((R_NUM + 64'd4) / 64'd8),
    33'((R_NUM + 64'd4) / 64'd9),   33'((R_NUM + 64'd5) / 64'd10),
    33'((R_NUM + 64'd5) / 64'd11),  33'((R_NUM + 64'd6) / 64'd12),
    33'((R_NUM + 64'd6) / 64'd13),  33'((R_NUM + 64'd7) / 64'd14),
    33'((R_NUM + 64'd7) / 64'd15),  33'((R_NUM + 64'd8) / 64'd16),
    33'((R_NUM + 64'd8) / 64'd17),  33'((R_NUM + 64'd9) / 64'd18),
    33'((R_NUM + 64'd9) / 64'd19),  33'((R_NUM + 64'd10) / 64'd20),
    33'((R_NUM + 64'd10) / 64'd21), 33'((R_NUM + 64'd11) / 64'd22),
    33'((R_NUM + 64'd11) / 64'd23), 33'((R_NUM + 64'd12) / 64'd24),
    33'((R_NUM + 64'd12) / 64'd25), 33'((R_NUM + 64'd13) / 64'd26),
    33'((R_NUM + 64'd13) / 64'd27), 33'((R_NUM + 64'd14) / 64'd28),
    33'((R_NUM + 64'd14) / 64'd29), 33'((R_NUM + 64'd15) / 64'd30),
    33'((R_NUM + 64'd15) / 64'd31), 33'((R_NUM + 64'd16) / 64'd32)
  };

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Clip a signed value to 48 bits; bit 48 of the result is the clip flag.
  function automatic logic [48:0] sat48(input logic signed [63:0] v);
    logic [48:0] r;
    if (v > VMAX) r = {1'b1, VMAX[47:0]};
    else if (v < VMIN) r = {1'b1, VMIN[47:0]};
    else r = {1'b0, v[47:0]};
    return r;
  endfunction

  // Apply a sign to a magnitude and clip; bit 48 is the clip flag.
  function automatic logic [48:0] sat_mag(input logic [104:0] q, input logic neg);
    logic [48:0] r;
    if (neg) begin
      if (q > 105'h8000_0000_0000) r = {1'b1, VMIN[47:0]};
      else r = {1'b0, 48'(-q[47:0])};
    end else begin
      if (q > 105'h7FFF_FFFF_FFFF) r = {1'b1, VMAX[47:0]};
      else r = {1'b0, q[47:0]};
    end
    return r;
  endfunction

  // Round a product magnitude to nearest, ties away from zero, drop sh bits, clip.
  function automatic logic [48:0] round_sat(input logic [103:0] mag, input logic neg,
                                            input logic [5:0] sh);
    logic [104:0] r;
    r = 105'(mag) + (105'd1 << (sh - 6'd1));
    return sat_mag(r >> sh, neg);
  endfunction

endpackage
`default_nettype wire

[rtl/core/lps_cell.sv]
// One cell of the value chain: holds a polynomial value and its clip flag.
`default_nettype none
module lps_cell (
  input  wire logic               clk,
  input  wire lps_pkg::cell_ctl_t ctl,
  input  wire logic signed [47:0] init_val,
  input  wire logic signed [47:0] d_in,
  input  wire logic               s_in,
  output logic signed [47:0]      q,
  output logic                    qs
);
  import lps_pkg::*;

  logic signed [47:0] val_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      val_r <= init_val;
      sat_r <= 1'b0;
    end else if (ctl.shift) begin
      val_r <= d_in;
      sat_r <= s_in;
    end
  end

  assign q  = val_r;
  assign qs = sat_r;
endmodule
`default_nettype wire

[rtl/core/lps_mul.sv]
// Multi-cycle magnitude multiplier, 64 by 40 bits, eight multiplier bits per cycle.
`default_nettype none
module lps_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [39:0]  b,
  output logic              done,
  output logic [103:0]      prod
);
  import lps_pkg::*;

  localparam int NSTEP = 5;

  logic [63:0]  a_r;
  logic [103:0] p_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [71:0]  hi;

  assign hi = 72'(p_r[103:40]) + 72'(a_r) * 72'(p_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(NSTEP - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {64'd0, b};
    end else if (busy_r) begin
      p_r <= {hi, p_r[39:8]};
    end
  end

  assign done = done_r;
  assign prod = p_r;
endmodule
`default_nettype wire

[rtl/core/lps_div.sv]
// Restoring divider: round(num * 2^FRAC_BITS / den), one quotient bit per cycle.
`default_nettype none
module lps_div #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [48:0] den,
  output logic             done,
  output logic             big,
  output logic [48:0]      q
);
  import lps_pkg::*;

  localparam int QBITS = 48;
  localparam int SH    = QBITS - FRAC_BITS;

  logic [48:0]  rem_r;
  logic [47:0]  lo_r;
  logic [47:0]  q_r;
  logic [48:0]  den_r;
  logic [5:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic         big_r;
  logic [127:0] nfull;
  logic [49:0]  rem2;
  logic         ge;

  assign nfull = 128'(num) << FRAC_BITS;
  assign rem2  = {rem_r, lo_r[47]};
  assign ge    = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (128'(num) >= (128'(den) << SH)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QBITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      big_r <= 128'(num) >= (128'(den) << SH);
      rem_r <= nfull[96:48];
      lo_r  <= nfull[47:0];
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 49'(rem2 - {1'b0, den_r}) : rem2[48:0];
      lo_r  <= {lo_r[46:0], 1'b0};
      q_r   <= {q_r[46:0], ge};
    end
  end

  assign done = done_r;
  assign big  = big_r;
  assign q    = {1'b0, q_r} + 49'(({rem_r, 1'b0} >= {1'b0, den_r}) ? 1 : 0);
endmodule
`default_nettype wire

[rtl/core/legendre_poly_sequence.sv]
// Top level of the Legendre polynomial run generator.
`default_nettype none
// Each input transaction carries a point u (signed, FRAC_BITS fraction bits) and a
// request kind, and produces min(order, MAX_ORDER) + 1 result transactions, one per
// degree k = 0..N in rising order, with last set on degree N. Kind 0 gives P_k(u),
// kind 1 gives P_k(u) less u (odd k) or 1 (even k) from degree 2 up, kind 2 gives the
// derivative P'_k(u); kind 3 acts as kind 0. Values are 48-bit signed and carry a
// saturation flag that also marks values computed from clipped ones. The block works
// on one transaction at a time: the recurrence walks a two-cell chain that holds
// P_k and P_(k-1), and every product but that of the endpoint closed form goes
// through one shared 64x40 multiplier. A degree of kinds 0 and 1 takes four
// products. Kind 2 adds one product and a 48-step bit-serial divider per degree
// from degree 1 up; kind 2 at u = +1 or -1 uses a closed form. A stalled result
// channel holds the sequencer in its emit state. The order register lies at byte
// address 0 of the APB port and resets to 2.
module legendre_poly_sequence #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 30
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lps_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lps_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lps_pkg::*;

  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

  // Configuration register.
  logic [4:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 5'd2;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      order_r <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, order_r};

  // Sequencer state and working registers.
  st_t state_r, state_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic signed [31:0] u_r, u_nxt;
  logic [4:0]         n_r, n_nxt;
  logic [4:0]         k_r, k_nxt;
  logic               endp_r, endp_nxt;
  logic               issued_r, issued_nxt;
  logic signed [47:0] t_r, t_nxt;
  logic               tf_r, tf_nxt;
  logic signed [63:0] s_r, s_nxt;
  logic signed [48:0] g_r, g_nxt;
  logic               gf_r, gf_nxt;
  logic signed [63:0] num_r, num_nxt;
  logic signed [47:0] res_r, res_nxt;
  logic               resf_r, resf_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  // Item-level decode of the incoming transaction.
  logic       in_fire;
  logic [1:0] in_kind;
  logic       in_endp;
  logic       out_free;
  logic       last_k;
  logic       is_der;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_kind  = (in_data.req_type == KIND_DER || in_data.req_type == KIND_SUB) ?
                    in_data.req_type : KIND_VAL;
  assign in_endp  = (in_kind == KIND_DER) &&
                    (64'(in_data.position) == ONE64 || 64'(in_data.position) == -ONE64);
  assign out_free = !out_valid_r || out_ready;
  assign last_k   = (k_r == n_r);
  assign is_der   = (kind_r == KIND_DER);

  // Value chain: cell 0 holds P_k, cell 1 holds P_(k-1).
  cell_ctl_t          cell_ctl;
  logic signed [47:0] cell_q [NCELL];
  logic               cell_s [NCELL];
  logic signed [47:0] new_p;
  logic               new_ps;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lps_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .init_val ((i == 0) ? 48'(ONE64) : 48'sd0),
      .d_in     ((i == 0) ? new_p  : cell_q[(i == 0) ? 0 : i - 1]),
      .s_in     ((i == 0) ? new_ps : cell_s[(i == 0) ? 0 : i - 1]),
      .q        (cell_q[i]),
      .qs       (cell_s[i])
    );
  end

  // Shared multiplier.
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [39:0]  mul_b;
  logic         mul_done;
  logic [103:0] mul_prod;
  logic         op_neg;
  logic [48:0]  rnd;
  logic signed [63:0] prod_int;
  logic signed [63:0] diff;

  lps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Divider for the derivative quotient.
  logic        div_start;
  logic        div_done;
  logic        div_big;
  logic [48:0] div_q;
  logic [48:0] div_res;

  lps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (abs64(num_r)),
    .den   (49'(abs64(64'(g_r)))),
    .done  (div_done),
    .big   (div_big),
    .q     (div_q)
  );

  assign div_res = div_big ? sat_mag(105'h1_0000_0000_0000, num_r[63] ^ g_r[48])
                           : sat_mag(105'(div_q), num_r[63] ^ g_r[48]);

  // Multiplier operand selection by state.
  assign diff = 64'(cell_q[1]) - 64'(t_r);

  always_comb begin
    mul_a  = abs64(64'(cell_q[0]));
    mul_b  = 40'(abs64(64'(u_r)));
    op_neg = 1'b0;
    case (state_r)
      ST_GSQ: begin
        mul_a  = abs64(64'(u_r));
        op_neg = 1'b0;
      end
      ST_TMUL: begin
        op_neg = u_r[31] ^ cell_q[0][47];
      end
      ST_DNUM: begin
        mul_a  = abs64(diff);
        mul_b  = 40'(k_r);
        op_neg = diff[63];
      end
      ST_S1: begin
        mul_a  = abs64(64'(t_r));
        mul_b  = 40'({k_r, 1'b1});
        op_neg = t_r[47];
      end
      ST_S2: begin
        mul_a  = abs64(64'(cell_q[1]));
        mul_b  = 40'(k_r);
        op_neg = cell_q[1][47];
      end
      ST_RMUL: begin
        mul_a  = abs64(s_r);
        mul_b  = 40'(RECIP[k_r]);
        op_neg = s_r[63];
      end
      default: ;
    endcase
  end

  assign rnd      = round_sat(mul_prod, op_neg,
                              (state_r == ST_RMUL) ? 6'd32 : 6'(FRAC_BITS));
  assign prod_int = op_neg ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_kind == KIND_DER && !in_endp) ? ST_GSQ : ST_PICK;
      end
      ST_GSQ:  if (mul_done) state_nxt = ST_PICK;
      ST_PICK: begin
        state_nxt = (endp_r || !is_der || k_r == 5'd0) ? ST_EMIT : ST_TMUL;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_k) state_nxt = ST_IDLE;
          else if (endp_r) state_nxt = ST_PICK;
          else if (is_der && k_r != 5'd0) state_nxt = ST_S1;
          else state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: if (mul_done) state_nxt = (is_der && k_r != 5'd0) ? ST_DNUM : ST_S1;
      ST_DNUM: if (mul_done) state_nxt = ST_DIV;
      ST_DIV:  if (g_r == 49'sd0 || div_done) state_nxt = ST_EMIT;
      ST_S1:   if (mul_done) state_nxt = ST_S2;
      ST_S2:   if (mul_done) state_nxt = ST_RMUL;
      ST_RMUL: if (mul_done) state_nxt = ST_PICK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  logic [48:0]        ep_a, ep_b, sub_v;
  logic signed [63:0] sub_op;
  logic               chain_f;

  assign ep_a    = sat48(64'(((10'(k_r) * (10'(k_r) + 10'd1)) >> 1)) << FRAC_BITS);
  assign ep_b    = sat48(-$signed(64'($signed(ep_a[47:0]))));
  assign sub_op  = k_r[0] ? 64'(u_r) : ONE64;
  assign sub_v   = sat48(64'(cell_q[0]) - sub_op);
  assign chain_f = cell_s[0] || cell_s[1];

  always_comb begin
    kind_nxt      = kind_r;
    u_nxt         = u_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    endp_nxt      = endp_r;
    t_nxt         = t_r;
    tf_nxt        = tf_r;
    s_nxt         = s_r;
    g_nxt         = g_r;
    gf_nxt        = gf_r;
    num_nxt       = num_r;
    res_nxt       = res_r;
    resf_nxt      = resf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cell_ctl      = '0;
    new_p         = $signed(rnd[47:0]);
    new_ps        = rnd[48] || tf_r || chain_f;
    mul_start     = !issued_r && (state_r == ST_GSQ || state_r == ST_TMUL ||
                                  state_r == ST_DNUM || state_r == ST_S1 ||
                                  state_r == ST_S2 || state_r == ST_RMUL);
    div_start     = !issued_r && state_r == ST_DIV && g_r != 49'sd0;
    issued_nxt    = issued_r;
    if (mul_start || div_start) issued_nxt = 1'b1;
    if (mul_done || div_done) issued_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt      = in_kind;
          u_nxt         = in_data.position;
          n_nxt         = (int'(order_r) > MAX_ORDER) ? 5'(MAX_ORDER) : order_r;
          endp_nxt      = in_endp;
          k_nxt         = 5'd0;
          g_nxt         = '0;
          gf_nxt        = 1'b0;
          cell_ctl.init = 1'b1;
        end
      end
      ST_GSQ: begin
        if (mul_done) begin
          g_nxt  = 49'(ONE64 - 64'($signed(rnd[47:0])));
          gf_nxt = rnd[48];
        end
      end
      ST_PICK: begin
        if (endp_r) begin
          if (u_r[31] && !k_r[0]) begin
            res_nxt  = $signed(ep_b[47:0]);
            resf_nxt = ep_a[48] || ep_b[48];
          end else begin
            res_nxt  = $signed(ep_a[47:0]);
            resf_nxt = ep_a[48];
          end
        end else if (!is_der) begin
          if (kind_r == KIND_SUB && k_r >= 5'd2) begin
            res_nxt  = $signed(sub_v[47:0]);
            resf_nxt = sub_v[48] || cell_s[0];
          end else begin
            res_nxt  = cell_q[0];
            resf_nxt = cell_s[0];
          end
        end else begin
          res_nxt  = '0;
          resf_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.degree       = k_r;
          out_data_nxt.result_value = res_r;
          out_data_nxt.saturated    = resf_r;
          out_data_nxt.last         = last_k;
          if (!last_k && endp_r) k_nxt = k_r + 5'd1;
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          t_nxt  = $signed(rnd[47:0]);
          tf_nxt = rnd[48];
        end
      end
      ST_DNUM: if (mul_done) num_nxt = prod_int;
      ST_DIV: begin
        if (g_r == 49'sd0) begin
          res_nxt  = '0;
          resf_nxt = tf_r || gf_r || chain_f;
        end else if (div_done) begin
          res_nxt  = $signed(div_res[47:0]);
          resf_nxt = div_res[48] || tf_r || gf_r || chain_f;
        end
      end
      ST_S1:   if (mul_done) s_nxt = prod_int;
      ST_S2:   if (mul_done) s_nxt = s_r - prod_int;
      ST_RMUL: begin
        if (mul_done) begin
          cell_ctl.shift = 1'b1;
          k_nxt          = k_r + 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    u_r        <= u_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    endp_r     <= endp_nxt;
    t_r        <= t_nxt;
    tf_r       <= tf_nxt;
    s_r        <= s_nxt;
    g_r        <= g_nxt;
    gf_r       <= gf_nxt;
    num_r      <= num_nxt;
    res_r      <= res_nxt;
    resf_r     <= resf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire
